@@ design/bounded_list_with_search_defines.svh @@
// assertion macros for the bounded list block
// expects signals named clk and rst_n in the module that uses them
`ifndef BOUNDED_LIST_WITH_SEARCH_DEFINES_SVH
`define BOUNDED_LIST_WITH_SEARCH_DEFINES_SVH

// property that holds at every clock edge out of reset
`define BLS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the same cycle
`define BLS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent in one cycle implies consequent in the next cycle
`define BLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/bls_pkg.sv @@
// constants and codes for the bounded list with search
// no dependencies
`timescale 1ns / 1ps

package bls_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int POS_W    = 6;
  localparam int LEN_W    = 7;

  typedef enum logic [1:0] {
    CMD_INSERT    = 2'd0,
    CMD_DEL_FIRST = 2'd1,
    CMD_DEL_LAST  = 2'd2,
    CMD_SEARCH    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

endpackage

@@ design/bounded_list_with_search.sv @@
// bounded list with search: ring store in one synchronous memory, scanned for search
// depends on bls_pkg and bounded_list_with_search_defines.svh
// results: insert and deletes register their result at the input transfer, so it shows in the
//   cycle after it; search registers it from S_SRCH when the entry in rdata_r hits or is the
//   last one, and at the transfer itself on an empty list
// commands: one at a time; the scan reads one entry per cycle from the single read port,
//   and in_ready stays low for the whole scan
// reset: rst_n synchronous active low empties the list; the store is not cleared
`timescale 1ns / 1ps

`include "bounded_list_with_search_defines.svh"

module bounded_list_with_search (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  bls_pkg::cmd_t                in_cmd,
  input  logic signed [31:0]           in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output bls_pkg::status_t             out_status,
  output logic [5:0]                   out_position,
  output logic [6:0]                   out_length
);
  import bls_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_SRCH
  } state_t;

  // ring index of head plus an offset, wrapped once
  function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] base,
                                            input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(CAPACITY)) begin
      sum = sum - (CNT_W+1)'(CAPACITY);
    end
    return IDX_W'(sum);
  endfunction

  // list storage, one write and one registered read per cycle
  logic signed [VAL_W-1:0] mem [CAPACITY];
  logic signed [VAL_W-1:0] rdata_r;

  state_t                  state_r;
  logic [IDX_W-1:0]        head_r;
  logic [CNT_W-1:0]        count_r;
  logic [IDX_W-1:0]        cmp_idx_r;   // position of the entry whose data sits in rdata_r
  logic signed [VAL_W-1:0] key_r;       // search value held during the scan

  logic                    out_valid_r;
  status_t                 out_status_r;
  logic [POS_W-1:0]        out_position_r;
  logic [LEN_W-1:0]        out_length_r;

  logic                    in_xfer;
  logic                    out_xfer;
  logic                    is_full;
  logic                    is_empty;
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_addr;
  logic [IDX_W-1:0]        rd_addr;
  logic [CNT_W-1:0]        next_off;
  logic                    hit;
  logic                    last_entry;
  logic                    scanning;
  logic                    rsp_full;    // result register holds a full status
  logic                    rsp_empty;   // result register holds an empty status

  // a new command only when idle and the result register is free or emptying
  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid_r && out_ready;

  assign is_full  = (count_r == CNT_W'(CAPACITY));
  assign is_empty = (count_r == '0);

  // insert writes just past the tail
  assign wr_en   = in_xfer && (in_cmd == CMD_INSERT) && !is_full;
  assign wr_addr = slot(head_r, count_r);

  // scan pipeline: while comparing entry i, fetch entry i+1
  assign next_off   = CNT_W'(cmp_idx_r) + CNT_W'(1);
  assign rd_addr    = (state_r == S_SRCH) ? slot(head_r, next_off) : head_r;
  assign hit        = (rdata_r == key_r);
  assign last_entry = (next_off == count_r);

  assign scanning  = (state_r == S_SRCH);
  assign rsp_full  = out_valid_r && (out_status_r == ST_FULL);
  assign rsp_empty = out_valid_r && (out_status_r == ST_EMPTY);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_value;
    end
    rdata_r <= mem[rd_addr];
  end

  // control state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      cmp_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            out_position_r <= '0;
            case (in_cmd)
              CMD_INSERT: begin
                out_valid_r <= 1'b1;
                if (is_full) begin
                  out_status_r <= ST_FULL;
                  out_length_r <= LEN_W'(count_r);
                end else begin
                  count_r      <= count_r + CNT_W'(1);
                  out_status_r <= ST_OK;
                  out_length_r <= LEN_W'(count_r + CNT_W'(1));
                end
              end
              CMD_DEL_FIRST: begin
                out_valid_r <= 1'b1;
                if (is_empty) begin
                  out_status_r <= ST_EMPTY;
                  out_length_r <= LEN_W'(count_r);
                end else begin
                  head_r       <= slot(head_r, CNT_W'(1));
                  count_r      <= count_r - CNT_W'(1);
                  out_status_r <= ST_OK;
                  out_length_r <= LEN_W'(count_r - CNT_W'(1));
                end
              end
              CMD_DEL_LAST: begin
                out_valid_r <= 1'b1;
                if (is_empty) begin
                  out_status_r <= ST_EMPTY;
                  out_length_r <= LEN_W'(count_r);
                end else begin
                  count_r      <= count_r - CNT_W'(1);
                  out_status_r <= ST_OK;
                  out_length_r <= LEN_W'(count_r - CNT_W'(1));
                end
              end
              CMD_SEARCH: begin
                if (is_empty) begin
                  out_valid_r  <= 1'b1;
                  out_status_r <= ST_NOTFOUND;
                  out_length_r <= LEN_W'(count_r);
                end else begin
                  // any older result leaves at this transfer
                  // head entry is being fetched this cycle
                  out_valid_r <= 1'b0;
                  key_r       <= in_value;
                  cmp_idx_r   <= '0;
                  state_r     <= S_SRCH;
                end
              end
              default: begin
                out_valid_r  <= 1'b1;
                out_status_r <= ST_NOTFOUND;
                out_length_r <= LEN_W'(count_r);
              end
            endcase
          end else if (out_xfer) begin
            out_valid_r <= 1'b0;
          end
        end
        S_SRCH: begin
          if (hit || last_entry) begin
            // result register is free here, it was checked at the command transfer
            out_valid_r    <= 1'b1;
            out_status_r   <= hit ? ST_OK : ST_NOTFOUND;
            out_position_r <= hit ? POS_W'(cmp_idx_r) : '0;
            out_length_r   <= LEN_W'(count_r);
            state_r        <= S_IDLE;
          end else begin
            cmp_idx_r <= IDX_W'(next_off);
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_position = out_position_r;
  assign out_length   = out_length_r;

  `BLS_ASSERT(a_count_bound, count_r <= CNT_W'(CAPACITY), "entry count above capacity")
  `BLS_ASSERT_IMPL(a_scan_range, scanning, next_off <= count_r, "scan past tail")
  `BLS_ASSERT_IMPL(a_full_status, rsp_full, is_full, "full status with room left")
  `BLS_ASSERT_IMPL(a_empty_status, rsp_empty, is_empty, "empty status on nonempty list")
  `BLS_ASSERT_NEXT(a_scan_cnt, scanning, $stable(count_r), "count changed during scan")
  `BLS_ASSERT_NEXT(a_scan_head, scanning, $stable(head_r), "head changed during scan")

endmodule
